@@ rtl/core/bhac_pkg.sv @@
// ----------------------------------------------------------------------------
// bhac_pkg
// Shared types and codes for the byte histogram anagram checker: request and
// result words, request codes and the command/status words of the count store.
// ----------------------------------------------------------------------------
package bhac_pkg;

    // request codes carried in req_type
    localparam logic [1:0] REQ_FIRST  = 2'd0;
    localparam logic [1:0] REQ_SECOND = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    // input word
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] byte_value;
    } req_word_t;

    // result word
    typedef struct packed {
        logic is_anagram;
        logic too_long;
    } res_word_t;

    // command from the front end to the count store
    typedef struct packed {
        logic rd;   // byte to count: issue counter read this cycle
        logic sub;  // byte of second string: decrement
        logic clr;  // finish leaves the pipe: clear the whole store
    } store_cmd_t;

    // status from the count store
    typedef struct packed {
        logic all_zero;  // no counter is nonzero
    } store_stat_t;

endpackage

@@ rtl/core/bhac_count_store.sv @@
// ----------------------------------------------------------------------------
// bhac_count_store
// Difference counters in a synchronous memory with a registered read. Each
// byte does read, +/-1 and write back, with forwarding of the last write.
// Per-entry valid bits give the zero state after reset and after a finish.
// ----------------------------------------------------------------------------
module bhac_count_store #(
    parameter int ALPHABET_SIZE  = 256,
    parameter int MAX_STRING_LEN = 255
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bhac_pkg::store_cmd_t             cmd,
    input  logic [$clog2(ALPHABET_SIZE)-1:0] addr,
    output bhac_pkg::store_stat_t            stat
);

    localparam int AW = $clog2(ALPHABET_SIZE);
    localparam int CW = $clog2(MAX_STRING_LEN + 1) + 1;
    localparam int NW = $clog2(ALPHABET_SIZE + 1);

    logic [CW-1:0]            mem [ALPHABET_SIZE];
    logic [CW-1:0]            rd_data_reg;
    logic [ALPHABET_SIZE-1:0] vld_reg;
    logic                     upd_reg;
    logic                     sub_reg;
    logic [AW-1:0]            addr_reg;
    logic                     fwd_vld_reg;
    logic [AW-1:0]            fwd_addr_reg;
    logic [CW-1:0]            fwd_data_reg;
    logic [NW-1:0]            nz_cnt_reg;
    logic [NW-1:0]            nz_cnt_next;
    logic [CW-1:0]            cnt_before;
    logic [CW-1:0]            cnt_after;

    // counter value seen by the item in the update stage
    always_comb
    begin
        if (fwd_vld_reg && (fwd_addr_reg == addr_reg))
        begin
            cnt_before = fwd_data_reg;
        end
        else if (vld_reg[addr_reg])
        begin
            cnt_before = rd_data_reg;
        end
        else
        begin
            cnt_before = '0;
        end
        cnt_after = sub_reg ? (cnt_before - CW'(1)) : (cnt_before + CW'(1));
    end

    // nonzero counter bookkeeping
    always_comb
    begin
        nz_cnt_next = nz_cnt_reg;
        if (cmd.clr)
        begin
            nz_cnt_next = '0;
        end
        else if (upd_reg)
        begin
            if ((cnt_before == '0) && (cnt_after != '0))
            begin
                nz_cnt_next = nz_cnt_reg + NW'(1);
            end
            else if ((cnt_before != '0) && (cnt_after == '0))
            begin
                nz_cnt_next = nz_cnt_reg - NW'(1);
            end
        end
    end

    // counter memory: write back and registered read
    always_ff @(posedge clk)
    begin
        if (upd_reg)
        begin
            mem[addr_reg] <= cnt_after;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    // update stage payload
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            sub_reg  <= cmd.sub;
            addr_reg <= addr;
        end
        if (upd_reg)
        begin
            fwd_addr_reg <= addr_reg;
            fwd_data_reg <= cnt_after;
        end
    end

    // control state: valid bits, forward flag, nonzero count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_reg     <= 1'b0;
            vld_reg     <= '0;
            fwd_vld_reg <= 1'b0;
            nz_cnt_reg  <= '0;
        end
        else
        begin
            upd_reg    <= cmd.rd;
            nz_cnt_reg <= nz_cnt_next;
            if (cmd.clr)
            begin
                vld_reg     <= '0;
                fwd_vld_reg <= 1'b0;
            end
            else if (upd_reg)
            begin
                vld_reg[addr_reg] <= 1'b1;
                fwd_vld_reg       <= 1'b1;
            end
        end
    end

    assign stat.all_zero = (nz_cnt_reg == '0);

`ifndef SYNTHESIS
    // a clear never meets a counter update
    a_clr_not_upd: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clr && upd_reg))
        else $error("store clear collided with counter update");

    // nonzero count stays within the alphabet
    a_nz_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nz_cnt_reg <= NW'(ALPHABET_SIZE))
        else $error("nonzero count above alphabet size");

    // a clear leaves no nonzero counter and no forwarded value
    a_clr_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr |=> (nz_cnt_reg == '0) && !fwd_vld_reg && (vld_reg == '0))
        else $error("store not empty after clear");
`endif

endmodule

@@ rtl/core/byte_histogram_anagram_check_top.sv @@
// A finish word on the input passes a stage register and then the result register
//   before its result word reaches the output.
// Throughput: one word per cycle while req_stall is low; the counter read-modify-write in the count
//   store, with forwarding of the last write, sustains this rate.
// req_stall rises only while a finish waits behind an untaken result word.
// Reset and each finish clear all counters at once through per-entry valid bits.
// ----------------------------------------------------------------------------
// byte_histogram_anagram_check_top
// Anagram check of two byte strings by a histogram of signed differences,
// with a length limit per string and a result word on each finish.
// ----------------------------------------------------------------------------
module byte_histogram_anagram_check_top #(
    parameter int ALPHABET_SIZE  = 256,
    parameter int MAX_STRING_LEN = 255
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  bhac_pkg::req_word_t  req,
    output logic                 res_valid,
    input  logic                 res_stall,
    output bhac_pkg::res_word_t  res
);

    localparam int AW = $clog2(ALPHABET_SIZE);
    localparam int LW = $clog2(MAX_STRING_LEN + 1);

    logic                  req_acc;
    logic                  is_first;
    logic                  is_second;
    logic                  is_finish;
    logic                  in_alpha;
    logic                  len_full;
    logic                  do_count;
    logic                  do_ovf;
    logic [LW-1:0]         first_len_reg;
    logic [LW-1:0]         first_len_next;
    logic [LW-1:0]         second_len_reg;
    logic [LW-1:0]         second_len_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic                  s1_fin_reg;
    logic                  s1_fin_next;
    logic                  s1_ovf_reg;
    logic                  s1_fire;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    bhac_pkg::res_word_t   res_reg;
    bhac_pkg::store_cmd_t  cmd;
    bhac_pkg::store_stat_t stat;

    // handshake and request decode
    assign s1_fire   = s1_fin_reg && !(res_valid_reg && res_stall);
    assign req_stall = s1_fin_reg && res_valid_reg && res_stall;
    assign req_acc   = req_valid && !req_stall;
    assign is_first  = (req.req_type == bhac_pkg::REQ_FIRST);
    assign is_second = (req.req_type == bhac_pkg::REQ_SECOND);
    assign is_finish = (req.req_type == bhac_pkg::REQ_FINISH);
    assign in_alpha  = ({1'b0, req.byte_value} < 9'(ALPHABET_SIZE));
    assign len_full  = is_first ? (first_len_reg == LW'(MAX_STRING_LEN))
                                : (second_len_reg == LW'(MAX_STRING_LEN));
    assign do_count  = req_acc && (is_first || is_second) && in_alpha && !len_full;
    assign do_ovf    = req_acc && (is_first || is_second) && in_alpha && len_full;

    // length tracking and overflow flag
    always_comb
    begin
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        ovf_next        = ovf_reg;
        if (req_acc && is_finish)
        begin
            first_len_next  = '0;
            second_len_next = '0;
            ovf_next        = 1'b0;
        end
        else
        begin
            if (do_count && is_first)
            begin
                first_len_next = first_len_reg + LW'(1);
            end
            if (do_count && is_second)
            begin
                second_len_next = second_len_reg + LW'(1);
            end
            if (do_ovf)
            begin
                ovf_next = 1'b1;
            end
        end
    end

    // finish stage and result register control
    always_comb
    begin
        s1_fin_next = s1_fin_reg;
        if (req_acc && is_finish)
        begin
            s1_fin_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_fin_next = 1'b0;
        end
        res_valid_next = res_valid_reg;
        if (s1_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    // count store command
    always_comb
    begin
        cmd.rd  = do_count;
        cmd.sub = is_second;
        cmd.clr = s1_fire;
    end

    bhac_count_store #(
        .ALPHABET_SIZE  (ALPHABET_SIZE),
        .MAX_STRING_LEN (MAX_STRING_LEN)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .addr  (req.byte_value[AW-1:0]),
        .stat  (stat)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_len_reg  <= '0;
            second_len_reg <= '0;
            ovf_reg        <= 1'b0;
            s1_fin_reg     <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            ovf_reg        <= ovf_next;
            s1_fin_reg     <= s1_fin_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_acc && is_finish)
        begin
            s1_ovf_reg <= ovf_reg;
        end
        if (s1_fire)
        begin
            res_reg.is_anagram <= stat.all_zero && !s1_ovf_reg;
            res_reg.too_long   <= s1_ovf_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    // the input stalls only for a finish blocked by a waiting result word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (s1_fin_reg && res_valid_reg))
        else $error("input stalled without a blocked finish");

    // a finish leaving the pipe always shows up as a result word
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> res_valid_reg)
        else $error("finish left the pipe without a result word");

    // string lengths never pass the limit
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (first_len_reg <= LW'(MAX_STRING_LEN)) && (second_len_reg <= LW'(MAX_STRING_LEN)))
        else $error("string length above limit");
`endif

endmodule
